@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define UOI_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define UOI_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/uoi_pkg.sv @@
`default_nettype none

package uoi_pkg;

  // Fixed-point constants of the integrator.
  localparam int CORDIC_STAGES = 16;
  localparam int DIV_STEPS     = 4;
  localparam int CNT_W         = 5;
  localparam int QUO_W         = 28;
  localparam int RECIP_SH      = 68;

  localparam logic [63:0] POS_DIV      = 64'd32768000000;
  localparam logic [63:0] YAW_DIV      = 64'd45000000;
  localparam logic [63:0] POS_HALF     = POS_DIV >> 1;
  // Rounding bias of the yaw numerator once it is divided by 64.
  localparam logic [47:0] YAW_BIAS     = 48'(YAW_DIV >> 7);

  // Reciprocals of the divisors shifted right by 15 (position) and 6 (yaw), scaled by 2^RECIP_SH and rounded up.
  // They give exact quotients for numerators below 2^48.
  localparam logic [71:0] POS_RECIP_FULL =
    ((72'd1 << RECIP_SH) + 72'(POS_DIV >> 15) - 72'd1) / 72'(POS_DIV >> 15);
  localparam logic [71:0] YAW_RECIP_FULL =
    ((72'd1 << RECIP_SH) + 72'(YAW_DIV >> 6) - 72'd1) / 72'(YAW_DIV >> 6);
  localparam logic [48:0] POS_RECIP = POS_RECIP_FULL[48:0];
  localparam logic [48:0] YAW_RECIP = YAW_RECIP_FULL[48:0];

  localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;
  localparam logic [23:0] RATE_COEF    = 24'd9370165;
  localparam logic [31:0] MAX_GAP_RESET = 32'd1000000;
  localparam logic signed [39:0] POS_MAX = 40'sh7F_FFFF_FFFF;
  localparam logic signed [39:0] POS_MIN = 40'sh80_0000_0000;

  // Controller states.
  typedef enum logic [3:0] {
    ST_IDLE, ST_CHECK, ST_COR1, ST_MUL1, ST_MUL2, ST_DIV, ST_COMMIT,
    ST_COR2S, ST_COR2, ST_OUT
  } state_t;

  // Quantity being integrated.
  typedef enum logic [1:0] {
    AX_X, AX_Y, AX_YAW
  } axis_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             load_in;
    logic             cor_start;
    logic             cor_half;
    logic             cor_step;
    logic [CNT_W-1:0] step_idx;
    logic             mul1;
    logic             mul2;
    logic             div_step;
    logic             commit;
    axis_t            axis;
    logic             out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic go;
    logic out_busy;
  } stat_t;

  // Arctangent of 2^-i in units of 2^-32 turn.
  function automatic logic [31:0] atan_turn(input logic [CNT_W-1:0] i);
    case (i)
      5'd0:  atan_turn = 32'd536870912;
      5'd1:  atan_turn = 32'd316933406;
      5'd2:  atan_turn = 32'd167458907;
      5'd3:  atan_turn = 32'd85004756;
      5'd4:  atan_turn = 32'd42667331;
      5'd5:  atan_turn = 32'd21354465;
      5'd6:  atan_turn = 32'd10679838;
      5'd7:  atan_turn = 32'd5340245;
      5'd8:  atan_turn = 32'd2670163;
      5'd9:  atan_turn = 32'd1335087;
      5'd10: atan_turn = 32'd667544;
      5'd11: atan_turn = 32'd333772;
      5'd12: atan_turn = 32'd166886;
      5'd13: atan_turn = 32'd83443;
      5'd14: atan_turn = 32'd41722;
      5'd15: atan_turn = 32'd20861;
      5'd16: atan_turn = 32'd10430;
      5'd17: atan_turn = 32'd5215;
      5'd18: atan_turn = 32'd2608;
      5'd19: atan_turn = 32'd1304;
      5'd20: atan_turn = 32'd652;
      5'd21: atan_turn = 32'd326;
      5'd22: atan_turn = 32'd163;
      5'd23: atan_turn = 32'd81;
      default: atan_turn = 32'd0;
    endcase
  endfunction

  // Round a Q30 CORDIC output to Q1.15, undoing the half-turn flip, saturating.
  function automatic logic signed [15:0] cor_q15(input logic signed [32:0] v,
                                                 input logic flip);
    logic signed [33:0] n;
    logic signed [33:0] r;
    n = {v[32], v};
    if (flip) begin
      n = -n;
    end
    r = (n + 34'sd16384) >>> 15;
    if (r > 34'sd32767) begin
      cor_q15 = 16'sh7FFF;
    end else if (r < -34'sd32768) begin
      cor_q15 = 16'sh8000;
    end else begin
      cor_q15 = r[15:0];
    end
  endfunction

endpackage

`default_nettype wire

@@ rtl/unicycle_odometry_integrator_unit.sv @@
// An item that advances the pose passes ST_CHECK, the iterative CORDIC (16 steps,
// run twice), the reciprocal multiply (4 partial products for x, y and yaw each) and ST_OUT,
// which waits while the previous result is still stalled; no new item is taken until it is loaded.
// An item that gives no result (first item, rejected gap) frees the input after ST_CHECK.
// Reset (rst_n, synchronous, active low) clears the pose and stamp, sets max_gap to 1000000.
`default_nettype none

module unicycle_odometry_integrator_unit import uoi_pkg::*; (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                cfg_we,
  input  wire         [31:0] cfg_wdata,
  input  wire                in_valid,
  output logic               in_ready,
  input  wire  signed [15:0] in_linear_velocity,
  input  wire  signed [15:0] in_angular_rate_deg,
  input  wire         [31:0] in_time_stamp,
  output logic               out_valid,
  input  wire                out_ready,
  output logic signed [39:0] out_pos_x,
  output logic signed [39:0] out_pos_y,
  output logic signed [15:0] out_heading,
  output logic signed [15:0] out_quat_z,
  output logic signed [15:0] out_quat_w,
  output logic signed [15:0] out_speed_echo,
  output logic signed [15:0] out_angular_rate_rad
);

  cmd_t  cmd;
  stat_t stat;

  // Sequencer.
  uoi_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Arithmetic and pose state.
  uoi_datapath u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .stat                 (stat),
    .cfg_we               (cfg_we),
    .cfg_wdata            (cfg_wdata),
    .in_linear_velocity   (in_linear_velocity),
    .in_angular_rate_deg  (in_angular_rate_deg),
    .in_time_stamp        (in_time_stamp),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_pos_x            (out_pos_x),
    .out_pos_y            (out_pos_y),
    .out_heading          (out_heading),
    .out_quat_z           (out_quat_z),
    .out_quat_w           (out_quat_w),
    .out_speed_echo       (out_speed_echo),
    .out_angular_rate_rad (out_angular_rate_rad)
  );

endmodule

`default_nettype wire

@@ rtl/uoi_ctrl.sv @@
`default_nettype none

module uoi_ctrl import uoi_pkg::*; (
  input  wire   clk,
  input  wire   rst_n,
  input  wire   in_valid,
  output logic  in_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t            state_r, state_nxt;
  axis_t             axis_r, axis_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;

  // State, axis and step counter registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      axis_r  <= AX_X;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      axis_r  <= axis_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    axis_nxt  = axis_r;
    cnt_nxt   = cnt_r;
    in_ready  = 1'b0;
    cmd       = '0;
    cmd.axis     = axis_r;
    cmd.step_idx = cnt_r;
    case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_in = in_valid;
        if (in_valid) begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (stat.go) begin
          cmd.cor_start = 1'b1;
          cmd.cor_half  = 1'b0;
          cnt_nxt       = '0;
          state_nxt     = ST_COR1;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_COR1: begin
        cmd.cor_step = 1'b1;
        if (cnt_r == CNT_W'(CORDIC_STAGES - 1)) begin
          cnt_nxt   = '0;
          axis_nxt  = AX_X;
          state_nxt = ST_MUL1;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_MUL1: begin
        cmd.mul1  = 1'b1;
        state_nxt = ST_MUL2;
      end
      ST_MUL2: begin
        cmd.mul2  = 1'b1;
        cnt_nxt   = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = ST_COMMIT;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_COMMIT: begin
        cmd.commit = 1'b1;
        case (axis_r)
          AX_X: begin
            axis_nxt  = AX_Y;
            state_nxt = ST_MUL1;
          end
          AX_Y: begin
            axis_nxt  = AX_YAW;
            state_nxt = ST_MUL2;
          end
          default: begin
            state_nxt = ST_COR2S;
          end
        endcase
      end
      ST_COR2S: begin
        cmd.cor_start = 1'b1;
        cmd.cor_half  = 1'b1;
        cnt_nxt       = '0;
        state_nxt     = ST_COR2;
      end
      ST_COR2: begin
        cmd.cor_step = 1'b1;
        if (cnt_r == CNT_W'(CORDIC_STAGES - 1)) begin
          cnt_nxt   = '0;
          state_nxt = ST_OUT;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_OUT: begin
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/uoi_datapath.sv @@
`default_nettype none

module uoi_datapath import uoi_pkg::*; (
  input  wire                clk,
  input  wire                rst_n,
  input  cmd_t               cmd,
  output stat_t              stat,
  input  wire                cfg_we,
  input  wire         [31:0] cfg_wdata,
  input  wire  signed [15:0] in_linear_velocity,
  input  wire  signed [15:0] in_angular_rate_deg,
  input  wire         [31:0] in_time_stamp,
  output logic               out_valid,
  input  wire                out_ready,
  output logic signed [39:0] out_pos_x,
  output logic signed [39:0] out_pos_y,
  output logic signed [15:0] out_heading,
  output logic signed [15:0] out_quat_z,
  output logic signed [15:0] out_quat_w,
  output logic signed [15:0] out_speed_echo,
  output logic signed [15:0] out_angular_rate_rad
);

  // Control and state registers.
  logic [31:0]        max_gap_r;
  logic               have_prev_r;
  logic [31:0]        prev_r;
  logic               go_r;
  logic signed [39:0] x_r, y_r;
  logic [15:0]        yaw_r;
  logic               out_valid_r;

  // Payload registers.
  logic signed [15:0] v_r, w_r;
  logic [30:0]        dt_r;
  logic signed [32:0] cx_r, cy_r;
  logic signed [33:0] cz_r;
  logic               flip_r;
  logic signed [31:0] prod_r;
  logic [47:0]        dnum_r;
  logic [96:0]        acc_r;
  logic               neg_r;

  // Gap check against the previous stamp.
  logic [31:0] diff;
  logic        go_nxt;
  assign diff   = in_time_stamp - prev_r;
  assign go_nxt = have_prev_r && (diff != 32'd0) && !diff[31] && (diff <= max_gap_r);

  // CORDIC start angle and one rotation step.
  logic [31:0]        ang, ang_f;
  logic               flip_nxt;
  logic signed [32:0] sx, sy;
  logic signed [33:0] at;
  assign ang      = cmd.cor_half ? {yaw_r[15], yaw_r, 15'd0} : {yaw_r, 16'd0};
  assign flip_nxt = ang[31] ^ ang[30];
  assign ang_f    = ang ^ {flip_nxt, 31'd0};
  assign sx       = cy_r >>> cmd.step_idx;
  assign sy       = cx_r >>> cmd.step_idx;
  assign at       = signed'({2'b00, atan_turn(cmd.step_idx)});

  // Cosine and sine of the current CORDIC result.
  logic signed [15:0] cos_q, sin_q;
  assign cos_q = cor_q15(cx_r, flip_r);
  assign sin_q = cor_q15(cy_r, flip_r);

  // Products feeding the dividers.
  logic [31:0] pneg;
  logic [30:0] pabs;
  logic [61:0] pmul;
  logic [63:0] pnum;
  logic [15:0] wneg, wabs;
  logic [46:0] ymul;
  assign pneg = -prod_r;
  assign pabs = prod_r[31] ? pneg[30:0] : prod_r[30:0];
  assign pmul = pabs * dt_r;
  assign pnum = {2'd0, pmul} + POS_HALF;
  assign wneg = -w_r;
  assign wabs = w_r[15] ? wneg : w_r;
  assign ymul = wabs * dt_r;

  // Division by a constant as a multiply by its reciprocal, one partial product a cycle.
  logic [48:0]      recip;
  logic [23:0]      nd;
  logic [24:0]      md;
  logic [48:0]      pp;
  logic [96:0]      ppsh;
  logic [QUO_W-1:0] quo;
  assign recip = (cmd.axis == AX_YAW) ? YAW_RECIP : POS_RECIP;
  assign nd    = cmd.step_idx[0] ? dnum_r[47:24] : dnum_r[23:0];
  assign md    = cmd.step_idx[1] ? recip[48:24] : {1'b0, recip[23:0]};
  assign pp    = {25'd0, nd} * {24'd0, md};
  always_comb begin
    case (cmd.step_idx[1:0])
      2'b00:   ppsh = {48'd0, pp};
      2'b11:   ppsh = {pp, 48'd0};
      default: ppsh = {24'd0, pp, 24'd0};
    endcase
  end
  assign quo = acc_r[RECIP_SH +: QUO_W];

  // Signed step and saturating position update.
  logic signed [40:0] qs, psum;
  logic signed [39:0] pcur, psat;
  assign qs   = neg_r ? -signed'({13'd0, quo}) : signed'({13'd0, quo});
  assign pcur = (cmd.axis == AX_Y) ? y_r : x_r;
  assign psum = {pcur[39], pcur} + qs;
  assign psat = (psum[40] != psum[39]) ? (psum[40] ? POS_MIN : POS_MAX) : psum[39:0];

  // Rate conversion from deg/s to 1/32 rad/s, rounded half away from zero.
  logic [39:0]        rmag;
  logic [39:0]        rsum;
  logic [15:0]        rq, rqn;
  logic signed [15:0] rate;
  assign rmag = wabs * RATE_COEF;
  assign rsum = rmag + 40'd8388608;
  assign rq   = rsum[39:24];
  assign rqn  = -rq;
  always_comb begin
    if (rq[15]) begin
      rate = w_r[15] ? 16'sh8000 : 16'sh7FFF;
    end else begin
      rate = w_r[15] ? signed'(rqn) : signed'(rq);
    end
  end

  // Control state, configuration and pose.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_gap_r   <= MAX_GAP_RESET;
      have_prev_r <= 1'b0;
      prev_r      <= '0;
      go_r        <= 1'b0;
      x_r         <= '0;
      y_r         <= '0;
      yaw_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        max_gap_r <= cfg_wdata;
      end
      if (cmd.load_in) begin
        have_prev_r <= 1'b1;
        prev_r      <= in_time_stamp;
        go_r        <= go_nxt;
      end
      if (cmd.commit) begin
        case (cmd.axis)
          AX_X:    x_r <= psat;
          AX_Y:    y_r <= psat;
          default: yaw_r <= neg_r ? yaw_r - quo[15:0] : yaw_r + quo[15:0];
        endcase
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Working registers of the CORDIC, multiplier and divider.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      v_r  <= in_linear_velocity;
      w_r  <= in_angular_rate_deg;
      dt_r <= diff[30:0];
    end
    if (cmd.cor_start) begin
      cx_r   <= CORDIC_GAIN;
      cy_r   <= '0;
      cz_r   <= signed'({{2{ang_f[31]}}, ang_f});
      flip_r <= flip_nxt;
    end else if (cmd.cor_step) begin
      if (!cz_r[33]) begin
        cx_r <= cx_r - sx;
        cy_r <= cy_r + sy;
        cz_r <= cz_r - at;
      end else begin
        cx_r <= cx_r + sx;
        cy_r <= cy_r - sy;
        cz_r <= cz_r + at;
      end
    end
    if (cmd.mul1) begin
      prod_r <= v_r * ((cmd.axis == AX_Y) ? sin_q : cos_q);
    end
    // The numerator is first divided by a power-of-two factor of the divisor.
    if (cmd.mul2) begin
      acc_r <= '0;
      if (cmd.axis == AX_YAW) begin
        dnum_r <= {ymul, 1'b0} + YAW_BIAS;
        neg_r  <= w_r[15];
      end else begin
        dnum_r <= pnum[62:15];
        neg_r  <= prod_r[31];
      end
    end else if (cmd.div_step) begin
      acc_r <= acc_r + ppsh;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_pos_x            <= x_r;
      out_pos_y            <= y_r;
      out_heading          <= yaw_r;
      out_quat_z           <= sin_q;
      out_quat_w           <= cos_q;
      out_speed_echo       <= v_r;
      out_angular_rate_rad <= rate;
    end
  end

  assign out_valid     = out_valid_r;
  assign stat.go       = go_r;
  assign stat.out_busy = out_valid_r && !out_ready;

endmodule

`default_nettype wire

@@ rtl/uoi_checker.sv @@
`default_nettype none
`include "assert_macros.svh"

module uoi_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        in_valid,
  input wire        in_ready,
  input wire        out_valid,
  input wire        out_ready,
  input wire [39:0] out_pos_x,
  input wire [15:0] out_heading
);

  // A stalled result stays offered and unchanged.
  `UOI_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result dropped while stalled")
  `UOI_ASSERT(a_out_stable, out_valid && !out_ready |=> $stable(out_pos_x) && $stable(out_heading), "stalled result changed")

  // The block works on one item at a time.
  `UOI_ASSERT(a_busy_after_in, in_valid && in_ready |=> !in_ready, "input taken on back-to-back cycles")

  // A result never appears right after an input transfer.
  `UOI_ASSERT(a_no_fast_out, $rose(out_valid) |-> !$past(in_valid && in_ready), "result too early")

endmodule

bind unicycle_odometry_integrator_unit uoi_checker u_uoi_checker (.*);

`default_nettype wire
